[design/lppe_pkg.sv]
// Package for the LED pixel pulse encoder.
// Holds widths, register reset values, register indexes and the queue entry type.
// No dependencies.
package lppe_pkg;

   localparam int DATA_BITS              = 24;
   localparam int MIN_WORDS              = 8;
   localparam int MAX_WORDS              = 24;
   localparam int DEFAULT_BITS_PER_PIXEL = 24;
   localparam int COLOUR_W               = 8;
   localparam int PATTERN_W              = 16;
   localparam int CSR_INDEX_W            = 1;
   localparam int QUEUE_DEPTH            = 2;

   localparam logic [PATTERN_W-1:0] ONE_PATTERN_RESET  = 16'hFF00;
   localparam logic [PATTERN_W-1:0] ZERO_PATTERN_RESET = 16'hE000;

   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_PATTERN  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_PATTERN = 1'b1;

   typedef struct packed {
      logic                 final_pixel;
      logic [DATA_BITS-1:0] bits;
   } pixel_entry_type;

   // one side of a queue transfer: valid flag and the entry it carries
   typedef struct packed {
      logic            valid;
      pixel_entry_type entry;
   } queue_xfer_type;

   // words sent per pixel, held to the range the pixel can supply
   function automatic int word_count(input int bits_per_pixel);
      int n;
      n = bits_per_pixel;
      if (n > MAX_WORDS) n = MAX_WORDS;
      if (n < MIN_WORDS) n = MIN_WORDS;
      return n;
   endfunction

endpackage

[design/lppe_if.sv]
// Channel interfaces of the LED pixel pulse encoder: pixel request and word response.
// Depends on lppe_pkg for field widths.
interface lppe_req_if import lppe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COLOUR_W-1:0] red;
   logic [COLOUR_W-1:0] green;
   logic [COLOUR_W-1:0] blue;
   logic                final_pixel;

   modport source (output valid, red, green, blue, final_pixel, input ready);
   modport sink   (input valid, red, green, blue, final_pixel, output ready);
endinterface

interface lppe_rsp_if import lppe_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PATTERN_W-1:0] pulse_word;
   logic                 pixel_done;
   logic                 frame_end;

   modport source (output valid, pulse_word, pixel_done, frame_end, input ready);
   modport sink   (input valid, pulse_word, pixel_done, frame_end, output ready);
endinterface

[design/lppe_front.sv]
// Front stage: takes pixel transfers and packs them into queue entries.
// Depends on lppe_pkg and lppe_req_if.
module lppe_front import lppe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   lppe_req_if.sink       req_bus,
   output queue_xfer_type push,
   input  logic           push_ready
);

   logic            stage_valid_ff, stage_valid_in;
   pixel_entry_type stage_entry_ff, stage_entry_in;
   logic            take;

   assign req_bus.ready = !stage_valid_ff || push_ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_entry_in = stage_entry_ff;
      if (take) begin
         stage_valid_in             = 1'b1;
         stage_entry_in.final_pixel = req_bus.final_pixel;
         // red leads, each byte most significant bit first
         stage_entry_in.bits        = {req_bus.red, req_bus.green, req_bus.blue};
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_entry_ff <= stage_entry_in;
   end

   assign push.valid = stage_valid_ff;
   assign push.entry = stage_entry_ff;

endmodule

[design/lppe_queue.sv]
// Short queue between the front stage and the word sequencer.
// Depends on lppe_pkg.
module lppe_queue import lppe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_xfer_type push,
   output logic           push_ready,
   output queue_xfer_type pop,
   input  logic           pop_ready
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   pixel_entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign pop.valid  = (fill_ff != '0);
   assign pop.entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("queue fill missed a transfer in");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

[design/lppe_back.sv]
// Word sequencer: holds the pattern registers and sends one pulse word per data bit.
// Depends on lppe_pkg and lppe_rsp_if.
module lppe_back import lppe_pkg::*; #(
   parameter int BITS_PER_PIXEL = DEFAULT_BITS_PER_PIXEL
) (
   input  logic                   clock,
   input  logic                   reset,
   input  queue_xfer_type         pop,
   output logic                   pop_ready,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PATTERN_W-1:0]   csr_data,
   lppe_rsp_if.source             rsp_bus
);

   localparam int WORDS = word_count(BITS_PER_PIXEL);
   localparam int CNT_W = $clog2(WORDS);

   logic [PATTERN_W-1:0] one_pattern_ff, one_pattern_in;
   logic [PATTERN_W-1:0] zero_pattern_ff, zero_pattern_in;
   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DATA_BITS-1:0] bits_ff, bits_in;
   logic                 final_ff, final_in;
   logic                 fire, last, load;

   assign fire      = busy_ff && rsp_bus.ready;
   assign last      = (count_ff == CNT_W'(WORDS - 1));
   assign pop_ready = !busy_ff || (fire && last);
   assign load      = pop.valid && pop_ready;

   always_comb begin
      one_pattern_in  = one_pattern_ff;
      zero_pattern_in = zero_pattern_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ONE_PATTERN:  one_pattern_in  = csr_data;
            CSR_ZERO_PATTERN: zero_pattern_in = csr_data;
            default:          ;
         endcase
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      bits_in  = bits_ff;
      final_in = final_ff;
      if (load) begin
         // start the next pixel straight after the last word leaves
         busy_in  = 1'b1;
         count_in = '0;
         bits_in  = pop.entry.bits;
         final_in = pop.entry.final_pixel;
      end else if (fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff + 1'b1;
            bits_in  = {bits_ff[DATA_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_pattern_ff  <= ONE_PATTERN_RESET;
         zero_pattern_ff <= ZERO_PATTERN_RESET;
         busy_ff         <= 1'b0;
         count_ff        <= '0;
      end else begin
         one_pattern_ff  <= one_pattern_in;
         zero_pattern_ff <= zero_pattern_in;
         busy_ff         <= busy_in;
         count_ff        <= count_in;
      end
      bits_ff  <= bits_in;
      final_ff <= final_in;
   end

   assign rsp_bus.valid      = busy_ff;
   assign rsp_bus.pulse_word = bits_ff[DATA_BITS-1] ? one_pattern_ff : zero_pattern_ff;
   assign rsp_bus.pixel_done = last;
   assign rsp_bus.frame_end  = last && final_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff <= CNT_W'(WORDS - 1)))
      else $error("word counter past end of pixel");

   a_word_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && !last) |=> (busy_ff && count_ff == $past(count_ff) + 1'b1))
      else $error("word counter did not advance after a transfer");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> (!busy_ff || (fire && last)))
      else $error("pixel loaded over one in progress");

endmodule

[design/led_pixel_pulse_encoder_top.sv]
// Top level of the LED pixel pulse encoder: front stage, queue and word sequencer.
// Depends on lppe_pkg, lppe_if, lppe_front, lppe_queue and lppe_back.
//
//   channel   direction  carries
//   req_bus   in         red, green, blue, final_pixel (one pixel per transfer)
//   rsp_bus   out        pulse_word, pixel_done, frame_end (one word per transfer)
//   csr_*     in         pattern register writes, index 0 one, index 1 zero
//
// A pixel is sent as BITS_PER_PIXEL (held to 8..24) words, one word a cycle while rsp_bus
// is ready; a queued next pixel's first word follows the last word with no gap.
// A pixel transfer passes the front stage register, the queue and the word sequencer.
// Synchronous reset empties the queue and restores the pattern reset values.
// A stalled response holds the word; pixels are taken until queue and front stage fill.
module led_pixel_pulse_encoder_top import lppe_pkg::*; #(
   parameter int BITS_PER_PIXEL = DEFAULT_BITS_PER_PIXEL
) (
   input  logic                   clock,
   input  logic                   reset,
   lppe_req_if.sink               req_bus,
   lppe_rsp_if.source             rsp_bus,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PATTERN_W-1:0]   csr_data
);

   queue_xfer_type push;
   queue_xfer_type pop;
   logic           push_ready;
   logic           pop_ready;

   lppe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_ready (push_ready)
   );

   lppe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   lppe_back #(
      .BITS_PER_PIXEL (BITS_PER_PIXEL)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_ready (pop_ready),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_bus   (rsp_bus)
   );

endmodule
